FILE: rtl/mles_pkg.sv
// ----------------------------------------------------------------------------
// mles_pkg
// Shared types, operation codes and saturation helpers for the Metropolis
// local energy sampler.
// ----------------------------------------------------------------------------
package mles_pkg;

  localparam int PSI_BITS = 30;
  localparam int T_BITS   = 28;

  localparam logic [63:0] PSI_ONE      = 64'd1 << PSI_BITS;
  localparam logic [63:0] E_INV        = 64'd395007542;
  localparam logic [3:0]  SERIES_TERMS = 4'd12;

  localparam logic [1:0] OP_MUL    = 2'd0;
  localparam logic [1:0] OP_MULSH  = 2'd1;
  localparam logic [1:0] OP_MULDIV = 2'd2;
  localparam logic [1:0] OP_SQRT   = 2'd3;

  localparam logic signed [63:0] E48_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] E48_MIN = -E48_MAX - 64'sd1;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [6:0]  sh;
  } unit_req_t;

  typedef struct packed {
    logic         done;
    logic [63:0]  q;
    logic [127:0] prod;
  } unit_rsp_t;

  typedef struct packed {
    logic [30:0]        mu;
    logic [30:0]        sigma;
    logic [30:0]        delta;
    logic [15:0]        nsteps;
    logic signed [31:0] start;
    logic               load_start;
  } cfg_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > E48_MAX) r = E48_MAX[47:0];
    else if (v < E48_MIN) r = E48_MIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? (64'd0 - v) : v;
    return r;
  endfunction

endpackage

FILE: rtl/mles_cfg.sv
// ----------------------------------------------------------------------------
// mles_cfg
// APB register file: gaussian centre, width, proposal width, block length
// and start position. A start position write also reloads an idle walker.
// ----------------------------------------------------------------------------
module mles_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mles_pkg::cfg_t     cfg
);
  import mles_pkg::*;

  localparam logic [2:0] REG_MU     = 3'd0;
  localparam logic [2:0] REG_SIGMA  = 3'd1;
  localparam logic [2:0] REG_DELTA  = 3'd2;
  localparam logic [2:0] REG_NSTEPS = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;

  logic [30:0]        mu;
  logic [30:0]        sigma;
  logic [30:0]        delta;
  logic [15:0]        nsteps;
  logic signed [31:0] start;
  logic               wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu     <= 31'd13421773;
      sigma  <= 31'd10066330;
      delta  <= 31'd16777216;
      nsteps <= 16'd1000;
      start  <= 32'sd0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_MU:     mu     <= pwdata[30:0];
        REG_SIGMA:  sigma  <= pwdata[30:0];
        REG_DELTA:  delta  <= pwdata[30:0];
        REG_NSTEPS: nsteps <= pwdata[15:0];
        REG_START:  start  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MU:     prdata = {1'b0, mu};
      REG_SIGMA:  prdata = {1'b0, sigma};
      REG_DELTA:  prdata = {1'b0, delta};
      REG_NSTEPS: prdata = {16'd0, nsteps};
      REG_START:  prdata = start;
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.mu         = mu;
    cfg.sigma      = sigma;
    cfg.delta      = delta;
    cfg.nsteps     = nsteps;
    cfg.start      = $signed(pwdata);
    cfg.load_start = wr && (paddr[4:2] == REG_START);
  end

endmodule

FILE: rtl/mles_unit.sv
// ----------------------------------------------------------------------------
// mles_unit
// Shared arithmetic unit: 64x64 multiply in four 32x32 partial products,
// then product, shifted product, or radix-2 restoring divide of the product;
// also a one bit per cycle integer square root. Shifts and divides saturate.
// ----------------------------------------------------------------------------
module mles_unit (
  input  logic                clk,
  input  logic                rst,
  input  mles_pkg::unit_req_t req,
  output mles_pkg::unit_rsp_t rsp
);
  import mles_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_POST = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;
  localparam logic [2:0] U_DONE = 3'd5;

  logic [2:0]   st;
  logic [1:0]   op;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [63:0]  d;
  logic [6:0]   sh;
  logic [127:0] prod;
  logic [64:0]  rem;
  logic [63:0]  q;
  logic [5:0]   cnt;
  logic [63:0]  sv;
  logic [63:0]  sr;
  logic [63:0]  sb;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  rem_sh;
  logic         qbit;
  logic [127:0] shifted;
  logic [63:0]  sr_b;
  logic         sq_take;
  logic [63:0]  sr_next;

  always_comb begin
    pa = cnt[1] ? a[63:32] : a[31:0];
    pb = cnt[0] ? b[63:32] : b[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rem_sh  = {rem[63:0], prod[63]};
    qbit    = rem_sh >= {1'b0, d};
    shifted = prod >> sh;
    sr_b    = sr + sb;
    sq_take = sv >= sr_b;
    sr_next = sq_take ? ((sr >> 1) + sb) : (sr >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= U_IDLE;
      cnt <= 6'd0;
    end else begin
      case (st)
        U_IDLE: begin
          if (req.start) begin
            op   <= req.op;
            a    <= req.a;
            b    <= req.b;
            d    <= req.d;
            sh   <= req.sh;
            prod <= 128'd0;
            cnt  <= 6'd0;
            if (req.op == OP_SQRT) begin
              sv <= req.a;
              sr <= 64'd0;
              sb <= 64'd1 << 62;
              st <= U_SQRT;
            end else begin
              st <= U_MUL;
            end
          end
        end
        U_MUL: begin
          prod <= prod + pp_sh;
          cnt  <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) begin
            st <= U_POST;
          end
        end
        U_POST: begin
          cnt <= 6'd0;
          case (op)
            OP_MUL: begin
              q  <= prod[63:0];
              st <= U_DONE;
            end
            OP_MULSH: begin
              q  <= (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];
              st <= U_DONE;
            end
            default: begin
              if ((d == 64'd0) || (prod[127:64] >= d)) begin
                q  <= {64{1'b1}};
                st <= U_DONE;
              end else begin
                rem <= {1'b0, prod[127:64]};
                st  <= U_DIV;
              end
            end
          endcase
        end
        U_DIV: begin
          rem <= qbit ? (rem_sh - {1'b0, d}) : rem_sh;
          prod[63:0] <= {prod[62:0], qbit};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            q  <= {prod[62:0], qbit};
            st <= U_DONE;
          end
        end
        U_SQRT: begin
          if (sq_take) begin
            sv <= sv - sr_b;
          end
          sr  <= sr_next;
          sb  <= sb >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            q  <= sr_next;
            st <= U_DONE;
          end
        end
        U_DONE: begin
          st <= U_IDLE;
        end
        default: st <= U_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.done = (st == U_DONE);
    rsp.q    = q;
    rsp.prod = prod;
  end

endmodule

FILE: rtl/metropolis_local_energy_sampler.sv
// ----------------------------------------------------------------------------
// metropolis_local_energy_sampler
// One Metropolis step of a double-gaussian walker per input item, with local
// energy and blocking statistics, sequenced over one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Each input item (two uniform fractions) yields one result item: the new
// walker position, whether the move was taken, the local energy there and,
// when the step closes a block, block mean, running mean and blocking error.
// The time an item takes is set by the shared unit: a division runs through
// its radix-2 divider unless it saturates at once, and each of the four
// gaussian evaluations needs up to 13 divisions plus up to 31 multiply
// steps for the integer part of the exponent. in_ready is low while an item
// is in work; a finished result waits in the output register while the
// next item is taken.
// ----------------------------------------------------------------------------
module metropolis_local_energy_sampler #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        u_proposal,
  input  logic [23:0]        u_accept,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position,
  output logic               accepted,
  output logic signed [47:0] local_energy,
  output logic               block_done,
  output logic signed [47:0] block_mean,
  output logic signed [47:0] running_mean,
  output logic [46:0]        running_error,
  output logic [15:0]        block_count
);
  import mles_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OFF  = 5'd1;
  localparam logic [4:0] S_GT   = 5'd2;
  localparam logic [4:0] S_GSQ  = 5'd3;
  localparam logic [4:0] S_HORN = 5'd4;
  localparam logic [4:0] S_EXPN = 5'd5;
  localparam logic [4:0] S_GP   = 5'd6;
  localparam logic [4:0] S_APY  = 5'd7;
  localparam logic [4:0] S_AL1  = 5'd8;
  localparam logic [4:0] S_AL2  = 5'd9;
  localparam logic [4:0] S_K1   = 5'd10;
  localparam logic [4:0] S_K2   = 5'd11;
  localparam logic [4:0] S_K3   = 5'd12;
  localparam logic [4:0] S_X2   = 5'd13;
  localparam logic [4:0] S_X4   = 5'd14;
  localparam logic [4:0] S_X5   = 5'd15;
  localparam logic [4:0] S_SUM  = 5'd16;
  localparam logic [4:0] S_BM   = 5'd17;
  localparam logic [4:0] S_SQ   = 5'd18;
  localparam logic [4:0] S_AVE  = 5'd19;
  localparam logic [4:0] S_AV2  = 5'd20;
  localparam logic [4:0] S_AVSQ = 5'd21;
  localparam logic [4:0] S_VAR  = 5'd22;
  localparam logic [4:0] S_SQRT = 5'd23;
  localparam logic [4:0] S_FIN  = 5'd24;

  localparam logic [63:0]        ONE_F   = 64'd1 << FRAC_BITS;
  localparam logic signed [63:0] BIG_RAW = 64'sd1000000 <<< FRAC_BITS;
  localparam logic signed [47:0] E_BIG   = sat48(BIG_RAW);
  localparam logic [63:0]        T_LIM   = 64'd8 << T_BITS;
  localparam logic [63:0]        P_LIM   = 64'd1 << 40;
  localparam logic [63:0]        V_LIM   = 64'd1 << 48;
  localparam logic [63:0]        X4_LIM  = 64'd1 << 50;
  localparam int                 K_SH    = 31 - FRAC_BITS;

  cfg_t      cfg;
  unit_req_t req;
  unit_rsp_t rsp;

  logic [4:0]         st;
  logic               issued;
  logic [23:0]        up;
  logic [23:0]        ua;
  logic signed [31:0] wx;
  logic signed [31:0] yv;
  logic               wsel;
  logic               gsel;
  logic [30:0]        tq;
  logic [35:0]        tsq;
  logic [30:0]        th;
  logic [3:0]         kk;
  logic [4:0]         nn;
  logic [30:0]        g1;
  logic [40:0]        p1;
  logic [31:0]        px;
  logic [31:0]        py;
  logic signed [42:0] numx;
  logic signed [42:0] numy;
  logic [31:0]        psi_n;
  logic signed [42:0] num_n;
  logic [63:0]        py2;
  logic [55:0]        t1;
  logic [63:0]        v;
  logic [46:0]        x2;
  logic [50:0]        x4;
  logic signed [49:0] kin;
  logic signed [47:0] e;
  logic signed [63:0] esum;
  logic [15:0]        step;
  logic [15:0]        bs;
  logic signed [63:0] som;
  logic [63:0]        somsq;
  logic signed [47:0] bmean;
  logic signed [47:0] rmean;
  logic [63:0]        ave2;
  logic [31:0]        err;
  logic               acc;
  logic               done_r;

  logic               op_state;
  logic [63:0]        sig_eff;
  logic [15:0]        nsteps_eff;
  logic signed [25:0] pd;
  logic [24:0]        pm;
  logic signed [31:0] x_cur;
  logic signed [33:0] cdist;
  logic [33:0]        dist_mag;
  logic [42:0]        num_mag;
  logic signed [32:0] off;
  logic signed [33:0] ysum;
  logic signed [31:0] ysat;
  logic [40:0]        pclamp;
  logic [31:0]        psi_new;
  logic signed [42:0] num_new;
  logic               acc_new;
  logic [31:0]        psi_sel;
  logic [63:0]        vs;
  logic [48:0]        vc;
  logic signed [63:0] pot;
  logic signed [63:0] signed_q;
  logic [64:0]        sq_sum;
  logic [63:0]        var_v;

  mles_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mles_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_ready = (st == S_IDLE);

  always_comb begin
    op_state   = (st != S_IDLE) && (st != S_SUM) && (st != S_FIN);
    sig_eff    = {33'd0, (cfg.sigma == 31'd0) ? 31'd1 : cfg.sigma};
    nsteps_eff = (cfg.nsteps == 16'd0) ? 16'd1 : cfg.nsteps;
    pd         = $signed({1'b0, up, 1'b0}) - 26'sd16777216;
    pm         = pd[25] ? 25'(-pd) : pd[24:0];
    x_cur      = wsel ? yv : wx;
    cdist      = gsel ? (34'(x_cur) + $signed({3'd0, cfg.mu}))
                      : (34'(x_cur) - $signed({3'd0, cfg.mu}));
    dist_mag   = cdist[33] ? 34'(-cdist) : cdist;
    num_mag    = num_n[42] ? 43'(-num_n) : num_n;

    off     = pd[25] ? -$signed({1'b0, 32'((rsp.q + 64'hFF_FFFF) >> 24)})
                     : $signed({1'b0, 32'(rsp.q >> 24)});
    ysum    = 34'(wx) + 34'(off);
    if (ysum > 34'sd2147483647) ysat = 32'h7FFF_FFFF;
    else if (ysum < -34'sd2147483648) ysat = 32'h8000_0000;
    else ysat = ysum[31:0];

    pclamp  = (rsp.q > P_LIM) ? P_LIM[40:0] : rsp.q[40:0];
    psi_new = {1'b0, g1} + {1'b0, th};
    num_new = $signed({2'b00, p1}) + $signed({2'b00, pclamp})
            - $signed({12'd0, g1}) - $signed({12'd0, th});

    acc_new = rsp.prod < {40'd0, py2, 24'd0};
    psi_sel = acc_new ? py : px;

    vs = rsp.q >> K_SH;
    vc = (vs > V_LIM) ? V_LIM[48:0] : vs[48:0];

    pot      = $signed({13'd0, x4}) - $signed(rsp.q);
    signed_q = $signed(rsp.q);
    sq_sum   = {1'b0, somsq} + {1'b0, rsp.q};
    var_v    = (ave2 > rsp.q) ? (ave2 - rsp.q) : 64'd0;
  end

  always_comb begin
    req.start = op_state && !issued;
    req.op    = OP_MULDIV;
    req.a     = 64'd0;
    req.b     = 64'd1;
    req.d     = 64'd1;
    req.sh    = 7'd0;
    case (st)
      S_OFF: begin
        req.op = OP_MUL;
        req.a  = 64'(pm);
        req.b  = 64'(cfg.delta);
      end
      S_GT: begin
        req.a = 64'(dist_mag);
        req.b = 64'd1 << T_BITS;
        req.d = sig_eff;
      end
      S_GSQ: begin
        req.op = OP_MULSH;
        req.a  = 64'(tq);
        req.b  = 64'(tq);
        req.sh = 7'(2 * T_BITS - PSI_BITS);
      end
      S_HORN: begin
        req.a = 64'(tsq[30:1]);
        req.b = 64'(th);
        req.d = 64'(kk) << PSI_BITS;
      end
      S_EXPN: begin
        req.op = OP_MULSH;
        req.a  = 64'(th);
        req.b  = E_INV;
        req.sh = 7'(PSI_BITS);
      end
      S_GP: begin
        req.op = OP_MULSH;
        req.a  = 64'(th);
        req.b  = 64'(tsq);
        req.sh = 7'(PSI_BITS);
      end
      S_APY: begin
        req.op = OP_MUL;
        req.a  = 64'(py);
        req.b  = 64'(py);
      end
      S_AL1: begin
        req.op = OP_MUL;
        req.a  = 64'(ua);
        req.b  = 64'(px);
      end
      S_AL2: begin
        req.op = OP_MUL;
        req.a  = 64'(t1);
        req.b  = 64'(px);
      end
      S_K1: begin
        req.a = 64'(num_mag);
        req.b = PSI_ONE;
        req.d = 64'(psi_n);
      end
      S_K2, S_K3: begin
        req.a = v;
        req.b = ONE_F;
        req.d = sig_eff;
      end
      S_X2: begin
        req.op = OP_MULSH;
        req.a  = mag64(64'(wx));
        req.b  = mag64(64'(wx));
        req.sh = 7'(FRAC_BITS);
      end
      S_X4: begin
        req.op = OP_MULSH;
        req.a  = 64'(x2);
        req.b  = 64'(x2);
        req.sh = 7'(FRAC_BITS);
      end
      S_X5: begin
        req.op = OP_MULSH;
        req.a  = 64'(x2);
        req.b  = 64'd5;
        req.sh = 7'd1;
      end
      S_BM: begin
        req.a = mag64(esum);
        req.d = 64'(nsteps_eff);
      end
      S_SQ: begin
        req.op = OP_MULSH;
        req.a  = mag64(64'(bmean));
        req.b  = mag64(64'(bmean));
        req.sh = 7'(FRAC_BITS);
      end
      S_AVE: begin
        req.a = mag64(som);
        req.d = 64'(bs);
      end
      S_AV2: begin
        req.a = somsq;
        req.d = 64'(bs);
      end
      S_AVSQ: begin
        req.op = OP_MULSH;
        req.a  = mag64(64'(rmean));
        req.b  = mag64(64'(rmean));
        req.sh = 7'(FRAC_BITS);
      end
      S_VAR: begin
        req.a = v;
        req.b = ONE_F;
        req.d = 64'(bs - 16'd1);
      end
      S_SQRT: begin
        req.op = OP_SQRT;
        req.a  = v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      issued    <= 1'b0;
      wx        <= 32'sd0;
      step      <= 16'd0;
      esum      <= 64'sd0;
      bs        <= 16'd0;
      som       <= 64'sd0;
      somsq     <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      if ((st == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (op_state && !issued) begin
        issued <= 1'b1;
      end else if (op_state && rsp.done) begin
        issued <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (cfg.load_start) begin
            wx <= cfg.start;
          end
          if (in_valid) begin
            up <= u_proposal;
            ua <= u_accept;
            st <= S_OFF;
          end
        end
        S_OFF: if (issued && rsp.done) begin
          yv   <= ysat;
          wsel <= 1'b0;
          gsel <= 1'b0;
          st   <= S_GT;
        end
        S_GT: if (issued && rsp.done) begin
          if (rsp.q >= T_LIM) begin
            th  <= 31'd0;
            tsq <= 36'd0;
            st  <= S_GP;
          end else begin
            tq <= rsp.q[30:0];
            st <= S_GSQ;
          end
        end
        S_GSQ: if (issued && rsp.done) begin
          tsq <= rsp.q[35:0];
          th  <= PSI_ONE[30:0];
          kk  <= SERIES_TERMS;
          st  <= S_HORN;
        end
        S_HORN: if (issued && rsp.done) begin
          th <= PSI_ONE[30:0] - rsp.q[30:0];
          if (kk == 4'd1) begin
            nn <= tsq[35:31];
            st <= (tsq[35:31] == 5'd0) ? S_GP : S_EXPN;
          end else begin
            kk <= kk - 4'd1;
          end
        end
        S_EXPN: if (issued && rsp.done) begin
          th <= rsp.q[30:0];
          nn <= nn - 5'd1;
          if (nn == 5'd1) begin
            st <= S_GP;
          end
        end
        S_GP: if (issued && rsp.done) begin
          if (!gsel) begin
            g1   <= th;
            p1   <= pclamp;
            gsel <= 1'b1;
            st   <= S_GT;
          end else if (!wsel) begin
            px   <= psi_new;
            numx <= num_new;
            wsel <= 1'b1;
            gsel <= 1'b0;
            st   <= S_GT;
          end else begin
            py   <= psi_new;
            numy <= num_new;
            st   <= S_APY;
          end
        end
        S_APY: if (issued && rsp.done) begin
          py2 <= rsp.q;
          st  <= S_AL1;
        end
        S_AL1: if (issued && rsp.done) begin
          t1 <= rsp.q[55:0];
          st <= S_AL2;
        end
        S_AL2: if (issued && rsp.done) begin
          acc   <= acc_new;
          psi_n <= psi_sel;
          num_n <= acc_new ? numy : numx;
          if (acc_new) begin
            wx <= yv;
          end
          if (psi_sel == 32'd0) begin
            e  <= E_BIG;
            st <= S_SUM;
          end else begin
            st <= S_K1;
          end
        end
        S_K1: if (issued && rsp.done) begin
          v  <= rsp.q;
          st <= S_K2;
        end
        S_K2: if (issued && rsp.done) begin
          v  <= rsp.q;
          st <= S_K3;
        end
        S_K3: if (issued && rsp.done) begin
          kin <= (num_n > 43'sd0) ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
          st  <= S_X2;
        end
        S_X2: if (issued && rsp.done) begin
          x2 <= rsp.q[46:0];
          st <= S_X4;
        end
        S_X4: if (issued && rsp.done) begin
          x4 <= (rsp.q > X4_LIM) ? X4_LIM[50:0] : rsp.q[50:0];
          st <= S_X5;
        end
        S_X5: if (issued && rsp.done) begin
          e  <= sat48(pot + 64'(kin));
          st <= S_SUM;
        end
        S_SUM: begin
          esum <= sat_add64(esum, 64'(e));
          if (({1'b0, step} + 17'd1) >= {1'b0, nsteps_eff}) begin
            step   <= 16'd0;
            done_r <= 1'b1;
            st     <= S_BM;
          end else begin
            step   <= step + 16'd1;
            done_r <= 1'b0;
            st     <= S_FIN;
          end
        end
        S_BM: if (issued && rsp.done) begin
          bmean <= sat48(esum[63] ? -signed_q : signed_q);
          esum  <= 64'sd0;
          st    <= (bs != 16'hFFFF) ? S_SQ : S_AVE;
        end
        S_SQ: if (issued && rsp.done) begin
          som   <= sat_add64(som, 64'(bmean));
          somsq <= sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
          bs    <= bs + 16'd1;
          st    <= S_AVE;
        end
        S_AVE: if (issued && rsp.done) begin
          rmean <= sat48(som[63] ? -signed_q : signed_q);
          st    <= S_AV2;
        end
        S_AV2: if (issued && rsp.done) begin
          ave2 <= rsp.q;
          st   <= S_AVSQ;
        end
        S_AVSQ: if (issued && rsp.done) begin
          v <= var_v;
          if (bs > 16'd1) begin
            st <= S_VAR;
          end else begin
            err <= 32'd0;
            st  <= S_FIN;
          end
        end
        S_VAR: if (issued && rsp.done) begin
          v  <= rsp.q;
          st <= S_SQRT;
        end
        S_SQRT: if (issued && rsp.done) begin
          err <= rsp.q[31:0];
          st  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((st == S_FIN) && (!out_valid || out_ready)) begin
      position      <= wx;
      accepted      <= acc;
      local_energy  <= e;
      block_done    <= done_r;
      block_mean    <= done_r ? bmean : 48'sd0;
      running_mean  <= done_r ? rmean : 48'sd0;
      running_error <= done_r ? 47'(err) : 47'd0;
      block_count   <= bs;
    end
  end

`ifndef SYNTHESIS
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> issued)
    else $error("arith unit finished with no operation outstanding");

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !issued)
    else $error("operation outstanding while idle");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted item");

  a_block_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_done) |-> (block_count != 16'd0))
    else $error("closed block with zero block count");
`endif

endmodule
